[hw/rtl/fltw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fltw_pkg
// Shared constants, types and helpers of the four-level page table walker.
// ----------------------------------------------------------------------------
package fltw_pkg;

   // The entry store depth must be a power of two.
   localparam int STORE_WORDS = 4096;
   localparam int WORD_ADDR_W = $clog2(STORE_WORDS);

   localparam int ENTRY_W = 64;
   localparam int PADDR_W = 52;
   localparam int VADDR_W = 48;
   localparam int INDEX_W = 9;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_SIZE    = 7;

   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   localparam logic [1:0] LVL_TOP  = 2'd0;
   localparam logic [1:0] LVL_GIG  = 2'd1;
   localparam logic [1:0] LVL_MEG  = 2'd2;
   localparam logic [1:0] LVL_PAGE = 2'd3;

   typedef struct packed {
      logic                   wr_en;
      logic [WORD_ADDR_W-1:0] wr_addr;
      logic [ENTRY_W-1:0]     wr_data;
      logic [WORD_ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic               valid;
      logic               translated;
      logic [VADDR_W-1:0] physical_address;
   } result_type;

   function automatic logic [INDEX_W-1:0] va_index(input logic [VADDR_W-1:0] va,
                                                   input logic [1:0] lvl);
      logic [INDEX_W-1:0] idx;
      case (lvl)
         LVL_TOP:  idx = va[47:39];
         LVL_GIG:  idx = va[38:30];
         LVL_MEG:  idx = va[29:21];
         LVL_PAGE: idx = va[20:12];
         default:  idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/fltw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fltw_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fltw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/fltw_walker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fltw_walker
// Sequencer that clears the entry store, performs entry writes and walks the
// four table levels through one shared entry address unit.
// ----------------------------------------------------------------------------
module fltw_walker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [fltw_pkg::PADDR_W-1:0]   req_table_address,
   input  logic [fltw_pkg::ENTRY_W-1:0]   req_entry_value,
   input  logic [fltw_pkg::ENTRY_W-1:0]   req_root_pointer,
   input  logic [fltw_pkg::VADDR_W-1:0]   req_virtual_address,
   output fltw_pkg::ram_req_type          ram_req,
   input  logic [fltw_pkg::ENTRY_W-1:0]   rd_data,
   output fltw_pkg::result_type           result,
   input  logic                           result_ready
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ISSUE = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam int FULL_WORD_W = 40 + fltw_pkg::INDEX_W;

   state_type                          state_ff, state_in;
   logic [fltw_pkg::WORD_ADDR_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic [1:0]                         level_ff, level_in;
   logic [fltw_pkg::ENTRY_W-1:0]       root_ff, root_in;
   logic [fltw_pkg::VADDR_W-1:0]       va_ff, va_in;
   logic                               res_translated_ff, res_translated_in;
   logic [fltw_pkg::VADDR_W-1:0]       res_pa_ff, res_pa_in;

   logic [fltw_pkg::ENTRY_W-1:0]       base_sel;
   logic [1:0]                         level_sel;
   logic [fltw_pkg::INDEX_W-1:0]       index_sel;
   logic [FULL_WORD_W-1:0]             full_word;
   logic [1:0]                         level_next;
   logic                               accept;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign level_next = 2'(level_ff + 2'd1);

   // Shared entry address unit: table base bits 51:12 joined with the index.
   always_comb begin
      if (state_ff == ST_ISSUE) begin
         base_sel  = root_ff;
         level_sel = fltw_pkg::LVL_TOP;
      end else begin
         base_sel  = rd_data;
         level_sel = level_next;
      end
      index_sel = fltw_pkg::va_index(va_ff, level_sel);
      full_word = {base_sel[51:12], index_sel};
   end

   always_comb begin
      ram_req.rd_addr = full_word[fltw_pkg::WORD_ADDR_W-1:0];
      if (state_ff == ST_CLEAR) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = clear_cnt_ff;
         ram_req.wr_data = '0;
      end else begin
         ram_req.wr_en   = accept && (req_opcode == fltw_pkg::OP_WRITE);
         ram_req.wr_addr = req_table_address[3 +: fltw_pkg::WORD_ADDR_W];
         ram_req.wr_data = req_entry_value;
      end
   end

   always_comb begin
      state_in          = state_ff;
      clear_cnt_in      = clear_cnt_ff;
      level_in          = level_ff;
      root_in           = root_ff;
      va_in             = va_ff;
      res_translated_in = res_translated_ff;
      res_pa_in         = res_pa_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               root_in           = req_root_pointer;
               va_in             = req_virtual_address;
               level_in          = fltw_pkg::LVL_TOP;
               res_translated_in = 1'b0;
               res_pa_in         = '0;
               if (req_opcode == fltw_pkg::OP_WRITE) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!rd_data[fltw_pkg::BIT_PRESENT]) begin
               state_in = ST_DONE;
            end else if (level_ff == fltw_pkg::LVL_GIG && rd_data[fltw_pkg::BIT_SIZE]) begin
               res_translated_in = 1'b1;
               res_pa_in         = {rd_data[47:30], va_ff[29:0]};
               state_in          = ST_DONE;
            end else if (level_ff == fltw_pkg::LVL_MEG && rd_data[fltw_pkg::BIT_SIZE]) begin
               res_translated_in = 1'b1;
               res_pa_in         = {rd_data[47:21], va_ff[20:0]};
               state_in          = ST_DONE;
            end else if (level_ff == fltw_pkg::LVL_PAGE) begin
               res_translated_in = 1'b1;
               res_pa_in         = {rd_data[47:12], va_ff[11:0]};
               state_in          = ST_DONE;
            end else begin
               level_in = level_next;
            end
         end
         ST_DONE: begin
            if (result_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
      level_ff          <= level_in;
      root_ff           <= root_in;
      va_ff             <= va_in;
      res_translated_ff <= res_translated_in;
      res_pa_ff         <= res_pa_in;
   end

   always_comb begin
      result.valid            = (state_ff == ST_DONE);
      result.translated       = res_translated_ff;
      result.physical_address = res_pa_ff;
   end

endmodule
`default_nettype wire

[hw/rtl/four_level_page_table_walker.sv]
// Requests are taken one at a time: none is taken until the last result has
// been handed to the output register. A translation reads one to four table
// levels, a chain of dependent reads through the registered entry store port;
// the result moves from the walker's done state into the output register once
// that register is free. After reset the entry store is cleared one word a
// cycle; no request is taken until every store word has been cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Page table walker with its own entry store and a registered result port.
// ----------------------------------------------------------------------------
module four_level_page_table_walker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [fltw_pkg::PADDR_W-1:0] req_table_address,
   input  logic [fltw_pkg::ENTRY_W-1:0] req_entry_value,
   input  logic [fltw_pkg::ENTRY_W-1:0] req_root_pointer,
   input  logic [fltw_pkg::VADDR_W-1:0] req_virtual_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_translated,
   output logic [fltw_pkg::VADDR_W-1:0] rsp_physical_address
);

   fltw_pkg::ram_req_type          ram_req;
   fltw_pkg::result_type           result;
   logic [fltw_pkg::ENTRY_W-1:0]   rd_data;
   logic                           out_free;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_translated_ff, rsp_translated_in;
   logic [fltw_pkg::VADDR_W-1:0]   rsp_pa_ff, rsp_pa_in;

   fltw_walker u_walker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_table_address   (req_table_address),
      .req_entry_value     (req_entry_value),
      .req_root_pointer    (req_root_pointer),
      .req_virtual_address (req_virtual_address),
      .ram_req             (ram_req),
      .rd_data             (rd_data),
      .result              (result),
      .result_ready        (out_free)
   );

   fltw_ram #(
      .WIDTH (fltw_pkg::ENTRY_W),
      .DEPTH (fltw_pkg::STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   // The output register is free when empty or when its transfer completes.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_translated_in = rsp_translated_ff;
      rsp_pa_in         = rsp_pa_ff;
      if (out_free) begin
         rsp_valid_in      = result.valid;
         rsp_translated_in = result.translated;
         rsp_pa_in         = result.physical_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_translated_ff <= rsp_translated_in;
      rsp_pa_ff         <= rsp_pa_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_translated       = rsp_translated_ff;
   assign rsp_physical_address = rsp_pa_ff;

endmodule
`default_nettype wire
